>>> sv/fas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fas_pkg;

    // Table size and timer width.
    localparam int TABLE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int POS_W       = $clog2(TABLE_DEPTH);

    // Field widths of the words on the ports.
    localparam int KIND_W    = 2;
    localparam int ELAPSED_W = 16;
    localparam int INDEX_W   = 6;
    localparam int OP_W      = 2;
    localparam int FRAME_W   = 16;
    localparam int HOLD_IN_W = 32;
    localparam int OUT_POS_W = 6;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [POS_W-1:0]     pos_t;

    // Input word kinds.
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // Table entry opcodes; any other code behaves as end.
    localparam logic [OP_W-1:0] OP_PLAY = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOP = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ELAPSED_W-1:0] elapsed;
        logic [INDEX_W-1:0]   entry_index;
        logic [OP_W-1:0]      entry_op;
        logic [FRAME_W-1:0]   entry_frame;
        logic [HOLD_IN_W-1:0] entry_hold;
        logic [INDEX_W-1:0]   entry_target;
    } fas_item_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame;
        time_t              hold;
        logic [INDEX_W-1:0] target;
    } fas_entry_t;

    localparam int ENTRY_W = $bits(fas_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_LOOP,
        ST_RST
    } fas_state_t;

    typedef struct packed {
        logic busy;
    } fas_status_t;

endpackage

`default_nettype wire

>>> sv/fas_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/fas_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module fas_in_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_kind,
    input  wire logic [15:0]          s_elapsed,
    input  wire logic [5:0]           s_entry_index,
    input  wire logic [1:0]           s_entry_op,
    input  wire logic [15:0]          s_entry_frame,
    input  wire logic [31:0]          s_entry_hold,
    input  wire logic [5:0]           s_entry_target,
    output logic                      item_valid,
    output fas_pkg::fas_item_t        item,
    input  wire logic                 item_take
);

    import fas_pkg::*;

    logic      buf_valid_reg;
    fas_item_t buf_reg;

    // The buffer refills in the same cycle that the engine drains it.
    assign s_ready    = !buf_valid_reg || item_take;
    assign item_valid = buf_valid_reg;
    assign item       = buf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            buf_valid_reg <= 1'b1;
        end else if (item_take) begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            buf_reg.kind         <= s_kind;
            buf_reg.elapsed      <= s_elapsed;
            buf_reg.entry_index  <= s_entry_index;
            buf_reg.entry_op     <= s_entry_op;
            buf_reg.entry_frame  <= s_entry_frame;
            buf_reg.entry_hold   <= s_entry_hold;
            buf_reg.entry_target <= s_entry_target;
        end
    end

endmodule

`default_nettype wire

>>> sv/fas_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fas_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    input  wire fas_pkg::fas_item_t   item,
    output logic                      item_take,
    output fas_pkg::fas_status_t      status,
    output logic                      ram_we,
    output fas_pkg::pos_t             ram_waddr,
    output fas_pkg::fas_entry_t       ram_wdata,
    output fas_pkg::pos_t             ram_raddr,
    input  wire fas_pkg::fas_entry_t  ram_rdata,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [15:0]               m_display_frame,
    output logic [5:0]                m_position,
    output logic                      m_finished,
    output logic                      m_bad_loop
);

    import fas_pkg::*;

    fas_state_t         state_reg, state_next;
    time_t              timer_reg, timer_next;
    pos_t               pos_reg, pos_next;
    logic [FRAME_W-1:0] play_frame_reg, play_frame_next;
    time_t              play_hold_reg, play_hold_next;
    logic               done_reg, done_next;
    logic               bad_reg, bad_next;
    pos_t               target_reg, target_next;

    logic               m_valid_reg;
    logic [FRAME_W-1:0] m_frame_reg;
    logic [5:0]         m_pos_reg;
    logic               m_fin_reg;
    logic               m_bad_reg;

    logic               out_free;
    logic               out_load;
    logic               out_bad;
    logic [TIME_BITS:0] sum;
    time_t              timer_sat;
    pos_t               pos_inc;

    assign out_free  = !m_valid_reg || m_ready;
    assign sum       = {1'b0, timer_reg} + (TIME_BITS + 1)'(item.elapsed);
    assign timer_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    assign pos_inc   = (pos_reg == POS_W'(TABLE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;

    assign ram_waddr        = POS_W'(item.entry_index);
    assign ram_wdata.op     = item.entry_op;
    assign ram_wdata.frame  = item.entry_frame;
    assign ram_wdata.hold   = TIME_BITS'(item.entry_hold);
    assign ram_wdata.target = item.entry_target;

    assign status.busy = (state_reg != ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        timer_next      = timer_reg;
        pos_next        = pos_reg;
        play_frame_next = play_frame_reg;
        play_hold_next  = play_hold_reg;
        done_next       = done_reg;
        bad_next        = bad_reg;
        target_next     = target_reg;
        item_take       = 1'b0;
        ram_we          = 1'b0;
        ram_raddr       = '0;
        out_load        = 1'b0;
        out_bad         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (item_valid && out_free) begin
                    item_take = 1'b1;
                    case (item.kind)
                        KIND_TICK: begin
                            if (done_reg) begin
                                out_load = 1'b1;
                            end else if (timer_sat >= play_hold_reg) begin
                                timer_next = '0;
                                pos_next   = pos_inc;
                                ram_raddr  = pos_inc;
                                state_next = ST_ADV;
                            end else begin
                                timer_next = timer_sat;
                                out_load   = 1'b1;
                            end
                        end
                        KIND_LOAD: begin
                            ram_we   = (32'(item.entry_index) < TABLE_DEPTH);
                            out_load = 1'b1;
                        end
                        KIND_RESTART: begin
                            ram_raddr  = '0;
                            bad_next   = 1'b0;
                            state_next = ST_RST;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADV: begin
                case (ram_rdata.op)
                    OP_PLAY: begin
                        play_frame_next = ram_rdata.frame;
                        play_hold_next  = ram_rdata.hold;
                        out_load        = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    OP_LOOP: begin
                        target_next = POS_W'(ram_rdata.target);
                        if (32'(ram_rdata.target) < TABLE_DEPTH) begin
                            ram_raddr  = POS_W'(ram_rdata.target);
                            state_next = ST_LOOP;
                        end else begin
                            ram_raddr  = '0;
                            bad_next   = 1'b1;
                            state_next = ST_RST;
                        end
                    end
                    default: begin
                        done_next  = 1'b1;
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_LOOP: begin
                if (ram_rdata.op == OP_PLAY) begin
                    pos_next        = target_reg;
                    play_frame_next = ram_rdata.frame;
                    play_hold_next  = ram_rdata.hold;
                    out_load        = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    ram_raddr  = '0;
                    bad_next   = 1'b1;
                    state_next = ST_RST;
                end
            end
            ST_RST: begin
                pos_next        = '0;
                timer_next      = '0;
                done_next       = 1'b0;
                play_frame_next = ram_rdata.frame;
                play_hold_next  = ram_rdata.hold;
                out_bad         = bad_reg;
                out_load        = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            timer_reg      <= '0;
            pos_reg        <= '0;
            play_frame_reg <= '0;
            play_hold_reg  <= '0;
            done_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            timer_reg      <= timer_next;
            pos_reg        <= pos_next;
            play_frame_reg <= play_frame_next;
            play_hold_reg  <= play_hold_next;
            done_reg       <= done_next;
            bad_reg        <= bad_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        target_reg <= target_next;
        if (out_load) begin
            m_frame_reg <= play_frame_next;
            m_pos_reg   <= OUT_POS_W'(pos_next);
            m_fin_reg   <= done_next;
            m_bad_reg   <= out_bad;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_display_frame = m_frame_reg;
    assign m_position      = m_pos_reg;
    assign m_finished      = m_fin_reg;
    assign m_bad_loop      = m_bad_reg;

endmodule

`default_nettype wire

>>> sv/frame_animation_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Word
// s_        s_valid / s_ready   kind, elapsed, entry_index/op/frame/hold/target
// m_        m_valid / m_ready   display_frame, position, finished, bad_loop
//
// Each accepted word is held in an input register, then enters the
// sequencer engine. Load words, ticks that do not finish the frame and
// ignored words are handled in the idle state, so they stream at one word
// per cycle while the output register is not stalled. A tick that finishes
// its frame reads the next command table entry, and the loop target too when
// that entry is a loop; a restart reads entry zero, and a bad loop target
// costs one more read of entry zero. The table has a single read port.
// Reset is synchronous and active low; it clears the timer, position, current
// play and done flag, while the command table holds nothing until written.
// A stalled result word is held in the output register; the input register
// still takes a new word while it waits.

module frame_animation_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_elapsed,
    input  wire logic [5:0]  s_entry_index,
    input  wire logic [1:0]  s_entry_op,
    input  wire logic [15:0] s_entry_frame,
    input  wire logic [31:0] s_entry_hold,
    input  wire logic [5:0]  s_entry_target,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_display_frame,
    output logic [5:0]       m_position,
    output logic             m_finished,
    output logic             m_bad_loop
);

    import fas_pkg::*;

    logic        item_valid;
    fas_item_t   item;
    logic        item_take;
    fas_status_t status;
    logic        ram_we;
    pos_t        ram_waddr;
    fas_entry_t  ram_wdata;
    pos_t        ram_raddr;
    fas_entry_t  ram_rdata;

    // Input register: decouples the upstream handshake from the engine.
    fas_in_stage u_in_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_elapsed      (s_elapsed),
        .s_entry_index  (s_entry_index),
        .s_entry_op     (s_entry_op),
        .s_entry_frame  (s_entry_frame),
        .s_entry_hold   (s_entry_hold),
        .s_entry_target (s_entry_target),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take)
    );

    // Command table: one write port for load words, one registered read port
    // used for the next entry, a loop target or entry zero on restart or a bad loop.
    fas_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer engine with the timer, current play and output register.
    fas_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take),
        .status          (status),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_display_frame (m_display_frame),
        .m_position      (m_position),
        .m_finished      (m_finished),
        .m_bad_loop      (m_bad_loop)
    );

    // The engine never pulls a new word while a table read is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !item_take)
        else $error("word taken while a table read is pending");

    // A word is only taken when the output register can hold its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_take |-> (!m_valid || m_ready))
        else $error("word taken with the result register full");

    // A bad loop restarts the sequence at entry zero, not done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_loop) |-> (m_position == 6'd0 && !m_finished))
        else $error("bad loop result not at a restarted position");

    // A table write only happens in the cycle that a word is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> item_take)
        else $error("table written without a load word");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the animation sequencer. Stimulus goes in through the
// s_ channel one word at a time, and every accepted word is run through a
// software copy of the sequencer that predicts the status word it must produce.
// A monitor on the m_ channel compares each result word, field by field, with
// the oldest prediction. Both channels idle at random in the random part only.
module tb;
    import fas_pkg::*;

    // Codes that the package leaves unnamed: an ignored word kind, and the
    // spare opcode, which behaves as end.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam logic [OP_W-1:0]   OP_ALT_END   = 2'd3;

    localparam time_t TIME_MAX       = '1;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    DRAIN_CYCLES   = 20;
    localparam int    RANDOM_WORDS   = 500;

    // One result word as the sequencer reports it.
    typedef struct packed {
        logic [FRAME_W-1:0]   frame;
        logic [OUT_POS_W-1:0] position;
        logic                 finished;
        logic                 bad_loop;
    } seq_status_t;

    // Software copy of the sequencer plus the queue of status words that it
    // predicts. It also tracks which table entries have been written, so that
    // the stimulus never makes the block read an entry that holds nothing yet.
    class frame_seq_scoreboard;
        fas_entry_t         cmd_table [TABLE_DEPTH];
        bit                 written   [TABLE_DEPTH];
        time_t              frame_timer;
        pos_t               position;
        logic [FRAME_W-1:0] play_frame;
        time_t              play_hold;
        bit                 finished;
        seq_status_t        pending [$];
        int                 error_count;

        function new();
            frame_timer = '0;
            position    = '0;
            play_frame  = '0;
            play_hold   = '0;
            finished    = 1'b0;
            error_count = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        // Back to entry zero, which supplies frame and hold whatever its opcode.
        function void restart_play();
            position    = '0;
            frame_timer = '0;
            finished    = 1'b0;
            play_frame  = cmd_table[0].frame;
            play_hold   = cmd_table[0].hold;
        endfunction

        // Timer value after a tick; it saturates rather than wrapping.
        function time_t timer_after(logic [ELAPSED_W-1:0] elapsed);
            logic [TIME_BITS:0] sum;
            sum = {1'b0, frame_timer} + elapsed;
            return (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS-1:0];
        endfunction

        function pos_t next_position();
            return (position == pos_t'(TABLE_DEPTH - 1)) ? pos_t'(0) : pos_t'(position + 1);
        endfunction

        // Returns an entry that a tick of this length would read before it has
        // been written, or -1 when the tick is safe to send.
        function int missing_entry(logic [ELAPSED_W-1:0] elapsed);
            pos_t nxt;
            pos_t tgt;
            if (finished || timer_after(elapsed) < play_hold) return -1;
            nxt = next_position();
            if (!written[nxt]) return int'(nxt);
            if (cmd_table[nxt].op != OP_LOOP) return -1;
            tgt = pos_t'(cmd_table[nxt].target);
            if (!written[tgt]) return int'(tgt);
            if (cmd_table[tgt].op != OP_PLAY && !written[0]) return 0;
            return -1;
        endfunction

        function void note_word(fas_item_t w);
            seq_status_t want;
            fas_entry_t  e;
            pos_t        tgt;
            want.bad_loop = 1'b0;
            case (w.kind)
                KIND_TICK: begin
                    // After an end entry, ticks change nothing until a restart.
                    if (!finished) begin
                        frame_timer = timer_after(w.elapsed);
                        if (frame_timer >= play_hold) begin
                            frame_timer = '0;
                            position    = next_position();
                            e           = cmd_table[position];
                            if (e.op == OP_PLAY) begin
                                play_frame = e.frame;
                                play_hold  = e.hold;
                            end else if (e.op == OP_LOOP) begin
                                tgt = pos_t'(e.target);
                                if (cmd_table[tgt].op == OP_PLAY) begin
                                    position   = tgt;
                                    play_frame = cmd_table[tgt].frame;
                                    play_hold  = cmd_table[tgt].hold;
                                end else begin
                                    restart_play();
                                    want.bad_loop = 1'b1;
                                end
                            end else begin
                                finished = 1'b1;
                            end
                        end
                    end
                end
                KIND_LOAD: begin
                    if (w.entry_index < TABLE_DEPTH) begin
                        e.op     = w.entry_op;
                        e.frame  = w.entry_frame;
                        e.hold   = time_t'(w.entry_hold);
                        e.target = w.entry_target;
                        cmd_table[w.entry_index] = e;
                        written[w.entry_index]   = 1'b1;
                    end
                end
                KIND_RESTART: begin
                    restart_play();
                end
                default: begin
                end
            endcase
            want.frame    = play_frame;
            want.position = OUT_POS_W'(position);
            want.finished = finished;
            pending = {pending, want};
        endfunction

        function void check_result(seq_status_t got);
            seq_status_t want;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: frame %0d position %0d",
                       got.frame, got.position);
                error_count++;
                return;
            end
            want = pending.pop_front();
            if (got.frame !== want.frame) begin
                $error("display_frame: expected %0d, got %0d", want.frame, got.frame);
                error_count++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                error_count++;
            end
            if (got.finished !== want.finished) begin
                $error("finished: expected %0b, got %0b", want.finished, got.finished);
                error_count++;
            end
            if (got.bad_loop !== want.bad_loop) begin
                $error("bad_loop: expected %0b, got %0b", want.bad_loop, got.bad_loop);
                error_count++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_kind;
    logic [15:0]          s_elapsed;
    logic [5:0]           s_entry_index;
    logic [1:0]           s_entry_op;
    logic [15:0]          s_entry_frame;
    logic [31:0]          s_entry_hold;
    logic [5:0]           s_entry_target;
    logic                 m_valid;
    logic                 m_ready;
    logic [15:0]          m_display_frame;
    logic [5:0]           m_position;
    logic                 m_finished;
    logic                 m_bad_loop;

    frame_seq_scoreboard sb;
    int words_sent     = 0;
    int stalled_cycles = 0;
    bit idle_words     = 1'b0;
    bit stall_results  = 1'b0;

    frame_animation_sequencer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_elapsed      (s_elapsed),
        .s_entry_index  (s_entry_index),
        .s_entry_op     (s_entry_op),
        .s_entry_frame  (s_entry_frame),
        .s_entry_hold   (s_entry_hold),
        .s_entry_target (s_entry_target),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_display_frame(m_display_frame),
        .m_position     (m_position),
        .m_finished     (m_finished),
        .m_bad_loop     (m_bad_loop)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Every field random; callers overwrite the ones that matter for the kind.
    function automatic fas_item_t random_word(logic [KIND_W-1:0] kind);
        fas_item_t w;
        w.kind         = kind;
        w.elapsed      = ELAPSED_W'($urandom);
        w.entry_index  = INDEX_W'($urandom);
        w.entry_op     = OP_W'($urandom);
        w.entry_frame  = FRAME_W'($urandom);
        w.entry_hold   = $urandom;
        w.entry_target = INDEX_W'($urandom);
        return w;
    endfunction

    // Mostly short holds so that frames advance every few ticks, with zero,
    // full-range and maximum holds mixed in.
    function automatic logic [HOLD_IN_W-1:0] pick_hold();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return '0;
        if (pick < 80) return $urandom_range(1, 32'h0004_0000);
        if (pick < 90) return $urandom;
        return '1;
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return '0;
        if (pick < 40) return '1;
        return ELAPSED_W'($urandom);
    endfunction

    // A load word for the given entry with random content, mostly play-frame.
    function automatic fas_item_t random_entry_word(logic [INDEX_W-1:0] index);
        fas_item_t w;
        w             = random_word(KIND_LOAD);
        w.entry_index = index;
        w.entry_op    = ($urandom_range(0, 99) < 60) ? OP_PLAY : OP_W'($urandom_range(1, 3));
        w.entry_hold  = pick_hold();
        return w;
    endfunction

    // Presents one word and holds it until the sequencer takes it. The
    // prediction is made at acceptance, so the next word sees current state.
    task automatic send_word(input fas_item_t w);
        if (idle_words && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= w.kind;
        s_elapsed      <= w.elapsed;
        s_entry_index  <= w.entry_index;
        s_entry_op     <= w.entry_op;
        s_entry_frame  <= w.entry_frame;
        s_entry_hold   <= w.entry_hold;
        s_entry_target <= w.entry_target;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_word(w);
        if (w.kind != KIND_IGNORED) words_sent++;
    endtask

    task automatic send_load(input int index, input logic [OP_W-1:0] op,
                             input logic [FRAME_W-1:0] frame,
                             input logic [HOLD_IN_W-1:0] hold,
                             input logic [INDEX_W-1:0] target);
        fas_item_t w;
        w              = random_word(KIND_LOAD);
        w.entry_index  = INDEX_W'(index);
        w.entry_op     = op;
        w.entry_frame  = frame;
        w.entry_hold   = hold;
        w.entry_target = target;
        send_word(w);
    endtask

    // A tick that would advance into an empty entry first gets that entry
    // filled with random content; this repeats until the tick is safe.
    task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
        fas_item_t w;
        int        missing;
        missing = sb.missing_entry(elapsed);
        while (missing >= 0) begin
            send_word(random_entry_word(INDEX_W'(missing)));
            missing = sb.missing_entry(elapsed);
        end
        w         = random_word(KIND_TICK);
        w.elapsed = elapsed;
        send_word(w);
    endtask

    task automatic send_restart();
        if (!sb.written[0]) send_word(random_entry_word('0));
        send_word(random_word(KIND_RESTART));
    endtask

    // Result side: random bursts of back-pressure while stall_results is set.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_results && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_display_frame, m_position, m_finished, m_bad_loop});
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        int phase;
        int len;
        int pick;
        sb             = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_kind         <= KIND_TICK;
        s_elapsed      <= '0;
        s_entry_index  <= '0;
        s_entry_op     <= OP_PLAY;
        s_entry_frame  <= '0;
        s_entry_hold   <= '0;
        s_entry_target <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Entry zero gets the widest frame and hold.
        send_load(0, OP_PLAY, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
        send_load(1, OP_PLAY, 16'h1234, 32'd0, 6'd0);
        send_load(2, OP_PLAY, 16'h00AB, 32'h0002_0000, 6'd0);
        send_load(3, OP_LOOP, 16'd0, 32'd0, 6'd1);
        // Out of reset the current hold is zero, so the first tick advances.
        send_tick(16'd0);
        // Zero hold: even a zero-length tick finishes the frame.
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        // Reaching the hold exactly advances into the loop back to entry one.
        send_tick(16'd2);
        // Now point the loop at an end entry, which is a bad target.
        send_load(3, OP_LOOP, 16'd0, 32'd0, 6'd5);
        send_load(5, OP_END, 16'd0, 32'd0, 6'd0);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_restart();
        send_word(random_word(KIND_IGNORED));
        // Rewriting entry zero leaves the frame that is playing untouched.
        send_load(0, OP_PLAY, 16'd7, 32'd0, 6'd0);
        send_tick(16'h8000);
        send_restart();
        // The spare opcode ends the sequence; ticks are then ignored.
        send_load(1, OP_ALT_END, 16'h5555, 32'd1, 6'd63);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        // Loop to the last entry, then advance past the table end to zero.
        send_load(63, OP_PLAY, 16'h0F0F, 32'd0, 6'd0);
        send_load(1, OP_LOOP, 16'd0, 32'd0, 6'd63);
        send_restart();
        send_tick(16'd0);
        send_tick(16'd0);
        send_load(1, OP_END, 16'd0, 32'd0, 6'd0);
        send_tick(16'd0);

        // Random part: mostly small programs of play-frame entries closed by a
        // loop or an end, then a restart and a run of ticks with some noise.
        phase = 0;
        while (words_sent < RANDOM_WORDS) begin
            idle_words    = ($urandom_range(0, 3) != 0);
            stall_results = ($urandom_range(0, 3) != 0);
            phase++;
            if (phase == 6) begin
                // Fill the whole table with short frames and walk it past the
                // end so the position wraps.
                for (int i = 0; i < TABLE_DEPTH; i++)
                    send_load(i, OP_PLAY, FRAME_W'($urandom),
                              $urandom_range(0, 32'h0000_8000), INDEX_W'($urandom));
                send_restart();
                repeat (TABLE_DEPTH + 6) send_tick('1);
            end else begin
                len = $urandom_range(2, 8);
                for (int i = 0; i < len; i++)
                    send_load(i, OP_PLAY, FRAME_W'($urandom), pick_hold(),
                              INDEX_W'($urandom));
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_load(len, OP_LOOP, FRAME_W'($urandom), $urandom,
                              INDEX_W'($urandom_range(0, len - 1)));
                else if (pick < 65)
                    send_load(len, OP_LOOP, FRAME_W'($urandom), $urandom,
                              INDEX_W'($urandom));
                else if (pick < 85)
                    send_load(len, OP_END, FRAME_W'($urandom), $urandom,
                              INDEX_W'($urandom));
                else
                    send_load(len, OP_ALT_END, FRAME_W'($urandom), $urandom,
                              INDEX_W'($urandom));
            end
            send_restart();
            repeat ($urandom_range(8, 30)) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_tick(pick_elapsed());
                else if (pick < 86)
                    send_word(random_word(KIND_IGNORED));
                else if (pick < 93)
                    send_word(random_entry_word(INDEX_W'($urandom)));
                else
                    send_restart();
            end
        end

        // Last part, no idling: a long hold on entry zero that a run of full
        // ticks builds up to, so the timer climbs over several words before
        // the frame finishes and the sequence moves on.
        idle_words    = 1'b0;
        stall_results = 1'b0;
        send_load(0, OP_PLAY, FRAME_W'($urandom), 32'h0008_0000, INDEX_W'($urandom));
        send_restart();
        repeat (12) send_tick('1);

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
